// ===== src/upd_pkg.sv =====
`timescale 1ns / 1ps

package upd_pkg;

   localparam logic [7:0] PctChar = 8'h25;
   localparam logic [7:0] SubstChar = 8'h3F;

   localparam int QueueDepth = 4;
   localparam int QueueIndexWidth = $clog2(QueueDepth);
   localparam int QueueCountWidth = $clog2(QueueDepth + 1);

   typedef struct packed {
      logic [7:0] in_byte;
      logic       in_last;
   } upd_req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       out_last;
   } upd_rsp_type;

   typedef struct packed {
      logic [1:0]  count;
      upd_rsp_type first;
      upd_rsp_type second;
   } upd_result_type;

   typedef enum logic [1:0] {
      PHASE_IDLE  = 2'd0,
      PHASE_PCT   = 2'd1,
      PHASE_FIRST = 2'd2
   } upd_phase_type;

   typedef struct packed {
      logic       valid;
      logic [3:0] value;
   } upd_hex_type;

   function automatic upd_hex_type hex_digit(input logic [7:0] c);
      upd_hex_type h;
      h.valid = 1'b1;
      h.value = 4'd0;
      if (c inside {[8'h30 : 8'h39]}) begin
         h.value = c[3:0];
      end else if (c inside {[8'h41 : 8'h46], [8'h61 : 8'h66]}) begin
         h.value = c[3:0] + 4'd9;
      end else begin
         h.valid = 1'b0;
      end
      return h;
   endfunction

endpackage

// ===== src/url_percent_decoder_unit.sv =====
`timescale 1ns / 1ps
// Channel  Direction  Handshake              Payload
// req      in         req_valid / req_ready  upd_req_type: in_byte, in_last
// rsp      out        rsp_valid / rsp_ready  upd_rsp_type: out_byte, out_last
//
// One item is accepted per cycle while req_ready is high; its results enter the result queue at the same edge
// and, when the queue is empty, are offered from the next cycle.
// The rate is set by the four-entry result queue: req_ready is high while at least two entries are free.
// An escape whose first byte after the percent sign ends the string gives two results from one item.
// Reset is synchronous and clears the escape state and the queue.

module url_percent_decoder_unit
   import upd_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  upd_req_type req_item,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output upd_rsp_type rsp_item
);

   upd_result_type result;
   logic           accept;

   assign accept = req_valid && req_ready;

   upd_decoder decoder (
      .clock      (clock),
      .reset      (reset),
      .item_valid (accept),
      .item       (req_item),
      .result     (result)
   );

   upd_rsp_queue rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (result),
      .space_ok  (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_item  (rsp_item)
   );

endmodule

// ===== src/upd_decoder.sv =====
`timescale 1ns / 1ps

module upd_decoder
   import upd_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           item_valid,
   input  upd_req_type    item,
   output upd_result_type result
);

   upd_phase_type phase_ff, phase_in;
   logic [7:0]    first_ff, first_in;
   upd_hex_type   hi_hex, lo_hex;
   logic [7:0]    value;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PHASE_IDLE;
         first_ff <= 8'd0;
      end else begin
         phase_ff <= phase_in;
         first_ff <= first_in;
      end
   end

   always_comb begin
      phase_in = phase_ff;
      first_in = first_ff;
      if (item_valid) begin
         phase_in = PHASE_IDLE;
         first_in = 8'd0;
         case (phase_ff)
            PHASE_IDLE: begin
               if (item.in_byte == PctChar && !item.in_last) begin
                  phase_in = PHASE_PCT;
               end
            end
            PHASE_PCT: begin
               if (!item.in_last) begin
                  phase_in = PHASE_FIRST;
                  first_in = item.in_byte;
               end
            end
            default: begin
               phase_in = PHASE_IDLE;
            end
         endcase
      end
   end

   always_comb begin
      hi_hex = hex_digit(first_ff);
      lo_hex = hex_digit(item.in_byte);
      if (!hi_hex.valid) begin
         value = 8'd0;
      end else if (!lo_hex.valid) begin
         value = {4'd0, hi_hex.value};
      end else begin
         value = {hi_hex.value, lo_hex.value};
      end
      if (value == 8'd0) begin
         value = SubstChar;
      end
   end

   always_comb begin
      result.count = 2'd0;
      result.first = '{out_byte: item.in_byte, out_last: item.in_last};
      result.second = '{out_byte: item.in_byte, out_last: item.in_last};
      case (phase_ff)
         PHASE_IDLE: begin
            if (!(item.in_byte == PctChar && !item.in_last)) begin
               result.count = 2'd1;
            end
         end
         PHASE_PCT: begin
            result.first = '{out_byte: PctChar, out_last: 1'b0};
            if (item.in_last) begin
               result.count = 2'd2;
            end
         end
         PHASE_FIRST: begin
            result.first = '{out_byte: value, out_last: item.in_last};
            result.count = 2'd1;
         end
         default: begin
            result.count = 2'd1;
         end
      endcase
      if (!item_valid) begin
         result.count = 2'd0;
      end
   end

   assert property (@(posedge clock) disable iff (reset)
      item_valid && item.in_last |=> phase_ff == PHASE_IDLE)
      else $error("Escape state survived the end of a string.");

   assert property (@(posedge clock) disable iff (reset)
      result.count == 2'd2 |-> phase_ff == PHASE_PCT && item.in_last)
      else $error("Two results outside a truncated escape.");

   assert property (@(posedge clock) disable iff (reset)
      phase_ff != PHASE_FIRST |-> first_ff == 8'd0)
      else $error("Stale first escape byte.");

endmodule

// ===== src/upd_rsp_queue.sv =====
`timescale 1ns / 1ps

module upd_rsp_queue
   import upd_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  upd_result_type push,
   output logic           space_ok,
   output logic           rsp_valid,
   input  logic           rsp_ready,
   output upd_rsp_type    rsp_item
);

   upd_rsp_type                entries_ff [QueueDepth];
   logic [QueueIndexWidth-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QueueIndexWidth-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QueueCountWidth-1:0] count_ff, count_in;
   logic [QueueIndexWidth-1:0] wr_next;
   logic                       pop;

   assign pop = rsp_valid && rsp_ready;
   assign wr_next = wr_ptr_ff + QueueIndexWidth'(1);
   assign space_ok = count_ff <= QueueCountWidth'(QueueDepth - 2);
   assign rsp_valid = count_ff != '0;
   assign rsp_item = entries_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff + QueueIndexWidth'(push.count);
      rd_ptr_in = rd_ptr_ff + QueueIndexWidth'(pop);
      count_in = count_ff + QueueCountWidth'(push.count) - QueueCountWidth'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.count != 2'd0) begin
         entries_ff[wr_ptr_ff] <= push.first;
      end
      if (push.count == 2'd2) begin
         entries_ff[wr_next] <= push.second;
      end
   end

   assert property (@(posedge clock) disable iff (reset)
      count_ff <= QueueCountWidth'(QueueDepth))
      else $error("Result queue overflow.");

   assert property (@(posedge clock) disable iff (reset)
      push.count != 2'd0 |-> space_ok)
      else $error("Results pushed without room.");

   assert property (@(posedge clock) disable iff (reset)
      pop && push.count == 2'd0 |=> count_ff == $past(count_ff) - QueueCountWidth'(1))
      else $error("Queue count lost track of a taken item.");

endmodule

// ===== bench/url_percent_decoder_unit_tb.sv =====
`timescale 1ns / 1ps

module url_percent_decoder_unit_tb;
   import upd_pkg::*;

   localparam logic [7:0] CharZero   = 8'h30;
   localparam logic [7:0] CharNine   = 8'h39;
   localparam logic [7:0] UpperA     = 8'h41;
   localparam logic [7:0] UpperF     = 8'h46;
   localparam logic [7:0] LowerA     = 8'h61;
   localparam logic [7:0] LowerF     = 8'h66;
   localparam int         RandomItems = 550;
   localparam int         ReportLimit = 10;

   typedef struct {
      upd_req_type req;
      int          typed_count;
      upd_rsp_type first;
      upd_rsp_type second;
   } directed_row_type;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   upd_req_type req_item;
   logic        rsp_valid;
   logic        rsp_ready;
   upd_rsp_type rsp_item;

   upd_phase_type    decode_phase = PHASE_IDLE;
   logic [7:0]       held_char = 8'h00;
   upd_rsp_type      step_chars [2];
   upd_rsp_type      expected_chars [$];
   directed_row_type directed_rows [$];

   int mismatch_count = 0;
   int checked_count = 0;
   int items_sent = 0;
   int strings_sent = 0;
   int burst_left = 0;

   url_percent_decoder_unit u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_item  (rsp_item)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   function automatic int hex_nibble(input logic [7:0] c);
      if (c >= CharZero && c <= CharNine) begin
         return int'(c) - int'(CharZero);
      end else if (c >= LowerA && c <= LowerF) begin
         return int'(c) - int'(LowerA) + 10;
      end else if (c >= UpperA && c <= UpperF) begin
         return int'(c) - int'(UpperA) + 10;
      end
      return -1;
   endfunction

   // Advances the decoder state by one byte and leaves its output characters in step_chars.
   function automatic int decode_step(input upd_req_type r);
      int produced;
      int hi;
      int lo;
      int value;
      produced = 0;
      case (decode_phase)
         PHASE_PCT: begin
            if (r.in_last) begin
               step_chars[0] = {PctChar, 1'b0};
               step_chars[1] = {r.in_byte, 1'b1};
               produced = 2;
               decode_phase = PHASE_IDLE;
               held_char = 8'h00;
            end else begin
               held_char = r.in_byte;
               decode_phase = PHASE_FIRST;
            end
         end
         PHASE_FIRST: begin
            hi = hex_nibble(held_char);
            lo = hex_nibble(r.in_byte);
            if (hi < 0) begin
               value = 0;
            end else if (lo < 0) begin
               value = hi;
            end else begin
               value = hi * 16 + lo;
            end
            if (value == 0) begin
               value = int'(SubstChar);
            end
            step_chars[0] = {8'(value), r.in_last};
            produced = 1;
            decode_phase = PHASE_IDLE;
            held_char = 8'h00;
         end
         default: begin
            if (r.in_byte == PctChar && !r.in_last) begin
               decode_phase = PHASE_PCT;
            end else begin
               step_chars[0] = {r.in_byte, r.in_last};
               produced = 1;
               decode_phase = PHASE_IDLE;
               held_char = 8'h00;
            end
         end
      endcase
      return produced;
   endfunction

   function automatic logic [7:0] random_hex_char();
      int digit;
      digit = $urandom_range(0, 15);
      if (digit < 10) begin
         return CharZero + 8'(digit);
      end else if ($urandom_range(0, 1) == 0) begin
         return UpperA + 8'(digit - 10);
      end
      return LowerA + 8'(digit - 10);
   endfunction

   // Mostly characters just outside the hex ranges, some hex digits, some anything.
   function automatic logic [7:0] random_escape_char();
      case ($urandom_range(0, 9))
         0: return 8'h2F;
         1: return 8'h3A;
         2: return 8'h40;
         3: return 8'h47;
         4: return 8'h60;
         5: return 8'h67;
         6: return random_hex_char();
         default: return 8'($urandom_range(1, 255));
      endcase
   endfunction

   task automatic drive_item(input upd_req_type r);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         burst_left = $urandom_range(1, 40);
         if (gap > 0) begin
            req_valid = 1'b0;
            repeat (gap) @(negedge clock);
         end
      end
      req_item = r;
      req_valid = 1'b1;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
      burst_left--;
      items_sent++;
   endtask

   task automatic send_and_predict(input upd_req_type r, input int typed_count,
                                   input upd_rsp_type first, input upd_rsp_type second);
      int produced;
      drive_item(r);
      produced = decode_step(r);
      if (typed_count < 0) begin
         for (int i = 0; i < produced; i++) begin
            expected_chars.push_back(step_chars[i]);
         end
      end else begin
         if (typed_count > 0) begin
            expected_chars.push_back(first);
         end
         if (typed_count > 1) begin
            expected_chars.push_back(second);
         end
      end
   endtask

   task automatic add_row(input logic [7:0] b, input logic l, input int n,
                          input logic [7:0] e0, input logic l0,
                          input logic [7:0] e1, input logic l1);
      directed_row_type row;
      row.req = {b, l};
      row.typed_count = n;
      row.first = {e0, l0};
      row.second = {e1, l1};
      directed_rows.push_back(row);
   endtask

   task automatic send_random_string();
      logic [7:0]  text [$];
      int          tokens;
      upd_req_type r;
      tokens = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 30) : $urandom_range(1, 8);
      repeat (tokens) begin
         case ($urandom_range(0, 9))
            0, 1, 2, 3: begin
               text.push_back(8'($urandom_range(1, 255)));
            end
            4, 5, 6: begin
               text.push_back(PctChar);
               text.push_back(random_hex_char());
               text.push_back(random_hex_char());
            end
            7: begin
               text.push_back(PctChar);
               text.push_back(random_escape_char());
               text.push_back(random_escape_char());
            end
            8: begin
               text.push_back(PctChar);
            end
            default: begin
               text.push_back(PctChar);
               text.push_back(random_hex_char());
            end
         endcase
      end
      foreach (text[i]) begin
         r.in_byte = text[i];
         r.in_last = (i == text.size() - 1);
         send_and_predict(r, -1, '0, '0);
      end
      strings_sent++;
   endtask

   initial begin
      int pattern;
      int span;
      rsp_ready = 1'b0;
      forever begin
         pattern = $urandom_range(0, 3);
         span = $urandom_range(16, 80);
         repeat (span) begin
            @(negedge clock);
            case (pattern)
               0: rsp_ready = 1'b1;
               1: rsp_ready = 1'($urandom_range(0, 1));
               2: rsp_ready = ($urandom_range(0, 3) == 0);
               default: rsp_ready = ~rsp_ready;
            endcase
         end
      end
   end

   always @(posedge clock) begin
      upd_rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_chars.size() == 0) begin
            if (mismatch_count < ReportLimit) begin
               $display("Unexpected output: byte %h last %b", rsp_item.out_byte,
                        rsp_item.out_last);
            end
            mismatch_count++;
         end else begin
            want = expected_chars.pop_front();
            checked_count++;
            if (rsp_item.out_byte !== want.out_byte || rsp_item.out_last !== want.out_last) begin
               if (mismatch_count < ReportLimit) begin
                  $display("Mismatch: expected byte %h last %b, got byte %h last %b",
                           want.out_byte, want.out_last, rsp_item.out_byte, rsp_item.out_last);
               end
               mismatch_count++;
            end
         end
      end
   end

   initial begin
      #1000000;
      $display("Regression FAIL");
      $finish;
   end

   initial begin
      int directed_items;
      reset = 1'b1;
      req_valid = 1'b0;
      req_item = '0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      add_row("A", 1'b0, 1, "A", 1'b0, 8'h00, 1'b0);
      add_row(8'hFF, 1'b0, 1, 8'hFF, 1'b0, 8'h00, 1'b0);
      add_row(8'h01, 1'b1, 1, 8'h01, 1'b1, 8'h00, 1'b0);
      add_row(PctChar, 1'b0, -1, 8'h00, 1'b0, 8'h00, 1'b0);
      add_row("4", 1'b0, -1, 8'h00, 1'b0, 8'h00, 1'b0);
      add_row("1", 1'b0, -1, 8'h00, 1'b0, 8'h00, 1'b0);
      add_row(PctChar, 1'b0, -1, 8'h00, 1'b0, 8'h00, 1'b0);
      add_row("f", 1'b0, -1, 8'h00, 1'b0, 8'h00, 1'b0);
      add_row("F", 1'b1, 1, 8'hFF, 1'b1, 8'h00, 1'b0);
      add_row(PctChar, 1'b0, -1, 8'h00, 1'b0, 8'h00, 1'b0);
      add_row("a", 1'b0, -1, 8'h00, 1'b0, 8'h00, 1'b0);
      add_row("z", 1'b0, -1, 8'h00, 1'b0, 8'h00, 1'b0);
      add_row(PctChar, 1'b0, -1, 8'h00, 1'b0, 8'h00, 1'b0);
      add_row("g", 1'b0, -1, 8'h00, 1'b0, 8'h00, 1'b0);
      add_row("1", 1'b0, 1, SubstChar, 1'b0, 8'h00, 1'b0);
      add_row(PctChar, 1'b0, -1, 8'h00, 1'b0, 8'h00, 1'b0);
      add_row("0", 1'b0, -1, 8'h00, 1'b0, 8'h00, 1'b0);
      add_row("0", 1'b0, 1, SubstChar, 1'b0, 8'h00, 1'b0);
      add_row(PctChar, 1'b1, 1, PctChar, 1'b1, 8'h00, 1'b0);
      add_row(PctChar, 1'b0, -1, 8'h00, 1'b0, 8'h00, 1'b0);
      add_row("B", 1'b1, 2, PctChar, 1'b0, "B", 1'b1);
      add_row(PctChar, 1'b0, -1, 8'h00, 1'b0, 8'h00, 1'b0);
      add_row(PctChar, 1'b0, -1, 8'h00, 1'b0, 8'h00, 1'b0);
      add_row("4", 1'b1, 1, SubstChar, 1'b1, 8'h00, 1'b0);

      foreach (directed_rows[i]) begin
         send_and_predict(directed_rows[i].req, directed_rows[i].typed_count,
                          directed_rows[i].first, directed_rows[i].second);
      end
      directed_items = items_sent;

      while (items_sent < directed_items + RandomItems) begin
         send_random_string();
      end
      req_valid = 1'b0;

      while (expected_chars.size() != 0) begin
         @(posedge clock);
      end
      repeat (8) @(posedge clock);

      $display("Sent %0d items (%0d directed, %0d random strings), checked %0d output bytes.",
               items_sent, directed_items, strings_sent, checked_count);
      $display("Strings mixed plain bytes, hex and malformed escapes, and escapes cut short.");
      if (mismatch_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("%0d mismatches in total.", mismatch_count);
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
